// ===== rtl/chunk_frustum_side_cull_assert.svh =====
// Assertion macros for the checker file cfsc_checker.sv.
`ifndef CHUNK_FRUSTUM_SIDE_CULL_ASSERT_SVH
`define CHUNK_FRUSTUM_SIDE_CULL_ASSERT_SVH

// same-cycle implication
`define CFSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfsc assertion failed");

// next-cycle implication
`define CFSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfsc assertion failed");

`endif

// ===== rtl/cfsc_pkg.sv =====
package cfsc_pkg;

    localparam int COLUMN_WIDTH  = 16;
    localparam int COLUMN_HEIGHT = 256;

    localparam int COORD_W = 16;
    localparam int COEF_W  = 32;
    // corner x/z coordinate, covers (c+1)*COLUMN_WIDTH
    localparam int POS_W   = COORD_W + $clog2(COLUMN_WIDTH) + 1;
    localparam int PROD_W  = COEF_W + POS_W;
    localparam int SUM_W   = PROD_W + 2;

    localparam int CFG_IDX_W = 4;
    localparam int NUM_REGS  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_NX   = 4'd0,
        REG_LEFT_NY   = 4'd1,
        REG_LEFT_NZ   = 4'd2,
        REG_LEFT_OFF  = 4'd3,
        REG_RIGHT_NX  = 4'd4,
        REG_RIGHT_NY  = 4'd5,
        REG_RIGHT_NZ  = 4'd6,
        REG_RIGHT_OFF = 4'd7
    } t_cfg_idx;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    function automatic t_prod mul_coef_pos(input t_coef a, input t_pos b);
        t_prod r;
        r = t_prod'(a) * t_prod'(b);
        return r;
    endfunction

endpackage

// ===== rtl/chunk_frustum_side_cull.sv =====
// channel    | direction | payload
// s_axis     | in        | tdata[15:0] chunk_x, tdata[31:16] chunk_z
// m_axis     | out       | tdata[0] in_view, tdata[7:1] zero
// cfg        | in        | index 0..7 plane coefficients, data 32-bit Q16.16
//
// Four-stage pipeline: corner coordinates, coefficient products, corner sums
// with sign test, face decision into the output register. One transaction per
// cycle when not stalled: all stages advance together whenever the output
// register is empty or being taken. Synchronous active-low reset clears the
// valid bits and the plane registers (all-zero planes cull everything).
module chunk_frustum_side_cull (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] chunk_x, [31:16] chunk_z
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] in_view, [7:1] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [cfsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import cfsc_pkg::*;

    t_coef r_nx  [2];
    t_coef r_ny  [2];
    t_coef r_nz  [2];
    t_coef r_off [2];

    logic [3:0] r_vld;
    logic       ce;

    t_pos  r_x0, r_x1, r_z0, r_z1;
    t_prod r_px0 [2];
    t_prod r_px1 [2];
    t_prod r_pz0 [2];
    t_prod r_pz1 [2];
    t_sum  r_bot [2];
    t_sum  r_top [2];
    logic [7:0] r_front [2];
    logic       r_view;

    t_sum         corner_sum [2][8];
    logic         both;
    logic [1:0]   part_l, part_r;
    t_pos         cx, cz;

    assign ce              = !r_vld[3] || i_m_axis_tready;
    assign o_s_axis_tready = ce;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_vld[3];
    assign o_m_axis_tdata  = {7'd0, r_view};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 2; p++) begin
                r_nx[p]  <= '0;
                r_ny[p]  <= '0;
                r_nz[p]  <= '0;
                r_off[p] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_LEFT_NX:   r_nx[0]  <= i_cfg_data;
                REG_LEFT_NY:   r_ny[0]  <= i_cfg_data;
                REG_LEFT_NZ:   r_nz[0]  <= i_cfg_data;
                REG_LEFT_OFF:  r_off[0] <= i_cfg_data;
                REG_RIGHT_NX:  r_nx[1]  <= i_cfg_data;
                REG_RIGHT_NY:  r_ny[1]  <= i_cfg_data;
                REG_RIGHT_NZ:  r_nz[1]  <= i_cfg_data;
                REG_RIGHT_OFF: r_off[1] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[2:0], i_s_axis_tvalid};
        end
    end

    assign cx = t_pos'($signed(i_s_axis_tdata[15:0]));
    assign cz = t_pos'($signed(i_s_axis_tdata[31:16]));

    // stage 1: corner coordinates
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_x0 <= t_pos'(cx * t_pos'(COLUMN_WIDTH));
            r_x1 <= t_pos'((cx + t_pos'(1)) * t_pos'(COLUMN_WIDTH));
            r_z0 <= t_pos'(cz * t_pos'(COLUMN_WIDTH));
            r_z1 <= t_pos'((cz + t_pos'(1)) * t_pos'(COLUMN_WIDTH));
        end
    end

    // stage 2: products, face base terms
    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int p = 0; p < 2; p++) begin
                r_px0[p] <= mul_coef_pos(r_nx[p], r_x0);
                r_px1[p] <= mul_coef_pos(r_nx[p], r_x1);
                r_pz0[p] <= mul_coef_pos(r_nz[p], r_z0);
                r_pz1[p] <= mul_coef_pos(r_nz[p], r_z1);
                r_bot[p] <= t_sum'(r_off[p]);
                r_top[p] <= t_sum'(t_sum'(r_ny[p]) * t_sum'(COLUMN_HEIGHT))
                            + t_sum'(r_off[p]);
            end
        end
    end

    // stage 3: corner sums, strictly positive test
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            for (int k = 0; k < 8; k++) begin
                corner_sum[p][k] =
                    ((k & 1) != 0 ? t_sum'(r_px1[p]) : t_sum'(r_px0[p]))
                  + ((k & 2) != 0 ? t_sum'(r_pz1[p]) : t_sum'(r_pz0[p]))
                  + ((k & 4) != 0 ? r_top[p] : r_bot[p]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int p = 0; p < 2; p++) begin
                for (int k = 0; k < 8; k++) begin
                    r_front[p][k] <= !corner_sum[p][k][SUM_W-1]
                                     && (corner_sum[p][k] != '0);
                end
            end
        end
    end

    // stage 4: face decision
    always_comb begin
        both = |(r_front[0] & r_front[1]);
        for (int f = 0; f < 2; f++) begin
            part_l[f] = (|r_front[0][f*4 +: 4]) && !(&r_front[0][f*4 +: 4]);
            part_r[f] = (|r_front[1][f*4 +: 4]) && !(&r_front[1][f*4 +: 4]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_view <= both || |(part_l & part_r);
        end
    end

endmodule

// ===== rtl/cfsc_checker.sv =====
`include "chunk_frustum_side_cull_assert.svh"

module cfsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);
    logic m_stall;
    assign m_stall = o_m_axis_tvalid && !i_m_axis_tready;

    `CFSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_stall, o_m_axis_tvalid)
    `CFSC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_stall, $stable(o_m_axis_tdata))
    `CFSC_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[7:1] == 7'd0)
    `CFSC_ASSERT_NOW(a_stall_blocks, i_clk, i_rst_n, m_stall, !o_s_axis_tready)
    `CFSC_ASSERT_NOW(a_empty_accepts, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)

endmodule

bind chunk_frustum_side_cull cfsc_checker u_cfsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
